// ===== sv/thide_pkg.sv =====
// ----------------------------------------------------------------------------
// thide_pkg
// Shared types, character codes and prefix tables for the trace header
// id extractor.
// ----------------------------------------------------------------------------
package thide_pkg;

  // candidate form bit positions
  localparam int FORM_TP = 0;  // fixed-layout traceparent form
  localparam int FORM_UT = 1;  // colon-separated hex form
  localparam int FORM_XD = 2;  // decimal form

  // reported kind codes
  localparam logic [1:0] KIND_TP = 2'd0;
  localparam logic [1:0] KIND_UT = 2'd1;
  localparam logic [1:0] KIND_XD = 2'd2;

  // prefix lengths
  localparam logic [4:0] LEN_TP = 5'd16;
  localparam logic [4:0] LEN_UT = 5'd14;
  localparam logic [4:0] LEN_XD = 5'd19;

  // id field limits, in byte pairs or digits
  localparam logic [4:0] TRACE_PAIRS = 5'd16;
  localparam logic [4:0] SPAN_PAIRS  = 5'd8;
  localparam logic [4:0] MAX_DIGITS  = 5'd20;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic        found;
    logic [1:0]  kind;
    logic [63:0] trace_high;
    logic [63:0] trace_low;
    logic [63:0] span;
  } thide_result_t;

  // "traceparent: 00-"
  function automatic logic [7:0] tp_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = 8'h74;
      4'd1:  c = 8'h72;
      4'd2:  c = 8'h61;
      4'd3:  c = 8'h63;
      4'd4:  c = 8'h65;
      4'd5:  c = 8'h70;
      4'd6:  c = 8'h61;
      4'd7:  c = 8'h72;
      4'd8:  c = 8'h65;
      4'd9:  c = 8'h6e;
      4'd10: c = 8'h74;
      4'd11: c = 8'h3a;
      4'd12: c = 8'h20;
      4'd13: c = 8'h30;
      4'd14: c = 8'h30;
      4'd15: c = 8'h2d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // colon-separated form prefix, 14 bytes
  function automatic logic [7:0] ut_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = 8'h75;
      4'd1:  c = 8'h62;
      4'd2:  c = 8'h65;
      4'd3:  c = 8'h72;
      4'd4:  c = 8'h2d;
      4'd5:  c = 8'h74;
      4'd6:  c = 8'h72;
      4'd7:  c = 8'h61;
      4'd8:  c = 8'h63;
      4'd9:  c = 8'h65;
      4'd10: c = 8'h2d;
      4'd11: c = 8'h69;
      4'd12: c = 8'h64;
      4'd13: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // decimal form prefix, 19 bytes
  function automatic logic [7:0] xd_char(logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:  c = 8'h78;
      5'd1:  c = 8'h2d;
      5'd2:  c = 8'h64;
      5'd3:  c = 8'h61;
      5'd4:  c = 8'h74;
      5'd5:  c = 8'h61;
      5'd6:  c = 8'h64;
      5'd7:  c = 8'h6f;
      5'd8:  c = 8'h67;
      5'd9:  c = 8'h2d;
      5'd10: c = 8'h74;
      5'd11: c = 8'h72;
      5'd12: c = 8'h61;
      5'd13: c = 8'h63;
      5'd14: c = 8'h65;
      5'd15: c = 8'h2d;
      5'd16: c = 8'h69;
      5'd17: c = 8'h64;
      5'd18: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // valid only where is_hex holds
  function automatic logic [3:0] hex_val(logic [7:0] c);
    return is_digit(c) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage

// ===== sv/trace_header_id_extractor.sv =====
// ----------------------------------------------------------------------------
// trace_header_id_extractor
// Recognizes a trace header at the start of a message payload and returns
// the trace and span ids it carries, one result word per message.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                          | tuser          | tlast
//   --------+-----+--------------------------------+----------------+------------
//   in_     | in  | [7:0] payload byte             | -              | last byte
//   out_    | out | [63:0] trace high, [127:64]    | [0] found,     | -
//           |     | trace low, [191:128] span      | [2:1] kind     |
//
// one payload byte is taken per cycle while no last byte is stalled; each byte is held
// in the input register, and the parser state and result register load behind it
// a result is registered in the output register as the last byte leaves the input register
// rst_n is synchronous; it clears the parser, the input stage and out_tvalid
// a held result blocks only the next last byte: non-last bytes keep flowing
// while out_tready is low, since they never produce a result word
//
module trace_header_id_extractor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] payload_byte
  input  logic          in_tlast,   // end_of_payload
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [191:0]  out_tdata,  // [63:0] trace_id_high, [127:64] trace_id_low,
                                    // [191:128] span_identifier
  output logic [2:0]    out_tuser   // [0] header_found, [2:1] header_kind
);
  import thide_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  thide_result_t out_res_r;

  thide_result_t res;
  logic          in_acc, stall, adv, load;

  // only a last byte needs room in the output register
  assign stall     = s1_valid_r && s1_last_r && out_valid_r && !out_tready;
  assign adv       = s1_valid_r && !stall;
  assign load      = adv && s1_last_r;
  assign in_tready = !s1_valid_r || !stall;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  thide_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (adv),
    .byte_i   (s1_byte_r),
    .last_i   (s1_last_r),
    .result_o (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.span, out_res_r.trace_low, out_res_r.trace_high};
  assign out_tuser  = {out_res_r.kind, out_res_r.found};

  // a result word only follows a last byte
  a_rose_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without a last byte");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> ((out_tdata == '0) && (out_tuser[2:1] == KIND_TP)))
    else $error("not-found result carries data");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      ((out_tuser[2:1] == KIND_TP) || (out_tuser[2:1] == KIND_UT) ||
       (out_tuser[2:1] == KIND_XD)))
    else $error("found result with unknown kind");

endmodule

// ===== sv/thide_parser.sv =====
// ----------------------------------------------------------------------------
// thide_parser
// Per-byte header parser: prefix match, hex pair capture and decimal
// accumulation, with the result of the message formed on its last byte.
// ----------------------------------------------------------------------------
module thide_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_i,   // one byte consumed this cycle
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  output thide_pkg::thide_result_t result_o  // valid when step_i and last_i
);
  import thide_pkg::*;

  typedef enum logic [6:0] {
    PH_PREFIX = 7'b0000001,
    PH_SKIP   = 7'b0000010,
    PH_LEAD   = 7'b0000100,
    PH_TRACE  = 7'b0001000,
    PH_SPAN   = 7'b0010000,
    PH_DIGITS = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        half_r, half_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [7:0]  tr_r [16];
  logic [7:0]  tr_nxt [16];
  logic [7:0]  sp_r [8];
  logic [7:0]  sp_nxt [8];
  logic [63:0] acc_r, acc_nxt;

  logic       c_hex, c_dig, strict, lead_space, trace_act, digit_act;
  logic [3:0] c_val;
  logic [7:0] sep;
  logic       hit_tp, hit_ut, hit_xd;
  logic       found_tp, found_ut, found_xd;
  logic [63:0] th, tl, sh;

  always_comb begin
    c_hex      = is_hex(byte_i);
    c_val      = hex_val(byte_i);
    c_dig      = is_digit(byte_i);
    strict     = cand_r[FORM_TP];
    sep        = strict ? CH_DASH : CH_COLON;
    lead_space = (byte_i == CH_SPACE);
    hit_tp = (pos_r >= LEN_TP) || (byte_i == tp_char(pos_r[3:0]));
    hit_ut = (pos_r >= LEN_UT) || (byte_i == ut_char(pos_r[3:0]));
    hit_xd = (pos_r >= LEN_XD) || (byte_i == xd_char(pos_r));
    trace_act = (phase_r == PH_TRACE) ||
                ((phase_r == PH_LEAD) && cand_r[FORM_UT] && !lead_space);
    digit_act = (phase_r == PH_DIGITS) ||
                ((phase_r == PH_LEAD) && cand_r[FORM_XD] && !lead_space);

    phase_nxt = phase_r;
    cand_nxt  = cand_r;
    pos_nxt   = (pos_r == 5'h1f) ? pos_r : (pos_r + 5'd1);
    half_nxt  = half_r;
    nib_nxt   = nib_r;
    idx_nxt   = idx_r;
    tr_nxt    = tr_r;
    sp_nxt    = sp_r;
    acc_nxt   = acc_r;

    case (phase_r)
      PH_PREFIX: begin
        cand_nxt = cand_r & {hit_xd, hit_ut, hit_tp};
        if (cand_nxt[FORM_TP] && (pos_r == LEN_TP - 5'd1)) begin
          phase_nxt = PH_TRACE;
          idx_nxt   = '0;
          half_nxt  = 1'b0;
        end else if (cand_nxt[FORM_UT] && (pos_r == LEN_UT - 5'd1)) begin
          phase_nxt = PH_LEAD;
        end else if (cand_nxt[FORM_XD] && (pos_r == LEN_XD - 5'd1)) begin
          phase_nxt = PH_SKIP;
        end
      end
      // byte after the decimal prefix is not looked at
      PH_SKIP: phase_nxt = PH_LEAD;
      PH_LEAD: begin
        if (lead_space) begin
          phase_nxt = cand_r[FORM_UT] ? PH_TRACE : PH_DIGITS;
        end
      end
      PH_SPAN: begin
        if (!half_r) begin
          if ((idx_r < SPAN_PAIRS) && c_hex) begin
            half_nxt = 1'b1;
            nib_nxt  = c_val;
          end else begin
            phase_nxt = PH_DONE;
            if (strict && (idx_r < SPAN_PAIRS)) cand_nxt = '0;
          end
        end else if (c_hex) begin
          sp_nxt[idx_r[2:0]] = {nib_r, c_val};
          idx_nxt  = idx_r + 5'd1;
          half_nxt = 1'b0;
        end else begin
          phase_nxt = PH_DONE;
          half_nxt  = 1'b0;
          if (strict) cand_nxt = '0;
        end
      end
      PH_TRACE, PH_DIGITS, PH_DONE: ;
      default: ;
    endcase

    if (trace_act) begin
      phase_nxt = PH_TRACE;
      if (!half_r) begin
        if ((idx_r < TRACE_PAIRS) && c_hex) begin
          half_nxt = 1'b1;
          nib_nxt  = c_val;
        end else if ((byte_i == sep) && (!strict || (idx_r == TRACE_PAIRS))) begin
          phase_nxt = PH_SPAN;
          idx_nxt   = '0;
        end else begin
          phase_nxt = PH_DONE;
          if (strict) cand_nxt = '0;
        end
      end else if (c_hex) begin
        tr_nxt[idx_r[3:0]] = {nib_r, c_val};
        idx_nxt  = idx_r + 5'd1;
        half_nxt = 1'b0;
      end else begin
        phase_nxt = PH_DONE;
        half_nxt  = 1'b0;
        if (strict) cand_nxt = '0;
      end
    end

    if (digit_act) begin
      phase_nxt = PH_DIGITS;
      if ((idx_r < MAX_DIGITS) && c_dig) begin
        acc_nxt = (acc_r << 3) + (acc_r << 1) + {60'd0, byte_i[3:0]};
        idx_nxt = idx_r + 5'd1;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // result of the message as it stands after this byte
  always_comb begin
    found_tp = cand_nxt[FORM_TP] && (idx_nxt == SPAN_PAIRS) &&
               ((phase_nxt == PH_SPAN) || (phase_nxt == PH_DONE));
    found_ut = cand_nxt[FORM_UT] && (phase_nxt != PH_PREFIX);
    found_xd = cand_nxt[FORM_XD] && (phase_nxt != PH_PREFIX);
    for (int i = 0; i < 8; i++) begin
      th[63-8*i -: 8] = tr_nxt[i];
      tl[63-8*i -: 8] = tr_nxt[i+8];
      sh[63-8*i -: 8] = sp_nxt[i];
    end
    result_o.found      = found_tp || found_ut || found_xd;
    result_o.kind       = found_ut ? KIND_UT : (found_xd ? KIND_XD : KIND_TP);
    result_o.trace_high = found_xd ? acc_nxt : ((found_tp || found_ut) ? th : '0);
    result_o.trace_low  = (found_tp || found_ut) ? tl : '0;
    result_o.span       = (found_tp || found_ut) ? sh : '0;
  end

  // rearm after the last byte of each message
  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && last_i)) begin
      phase_r <= PH_PREFIX;
      cand_r  <= 3'b111;
      pos_r   <= '0;
      half_r  <= 1'b0;
      nib_r   <= '0;
      idx_r   <= '0;
      acc_r   <= '0;
      for (int i = 0; i < 16; i++) tr_r[i] <= '0;
      for (int i = 0; i < 8; i++) sp_r[i] <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      half_r  <= half_nxt;
      nib_r   <= nib_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      tr_r    <= tr_nxt;
      sp_r    <= sp_nxt;
    end
  end

  // forms differ in their first byte
  a_one_form: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 5'd0) |-> $onehot0(cand_r))
    else $error("more than one header form still open");

  a_form_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_SKIP) || (phase_r == PH_LEAD) || (phase_r == PH_DIGITS))
      |-> $onehot(cand_r))
    else $error("post-prefix phase without a matched form");

  a_half_phase: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> ((phase_r == PH_TRACE) || (phase_r == PH_SPAN)))
    else $error("pending nibble outside an id field");

endmodule

// ===== test/trace_header_id_extractor_test.sv =====
// ----------------------------------------------------------------------------
// trace_header_id_extractor_test
// Streams whole messages into the extractor: valid and broken headers of all
// three forms, truncated, long and noise messages. Each taken byte updates a
// local header decoder, and each result word is checked field by field
// against the oldest decoded header. Both sides idle at random.
// ----------------------------------------------------------------------------
module trace_header_id_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import thide_pkg::*;

  localparam int WINDOW_BYTES    = 256;
  localparam int HEAD_BYTES      = 72;   // only the leading bytes matter
  localparam int POS_LIMIT       = 511;
  localparam int RANDOM_BYTES    = 360;
  localparam int RANDOM_MESSAGES = 6;
  localparam int HOLD_LEN        = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  // header prefixes, first byte in the highest bits
  localparam logic [8*16-1:0] TP_PREFIX    = "traceparent: 00-";
  localparam logic [8*14-1:0] COLON_PREFIX = {8'h75, 8'h62, 8'h65, 8'h72, "-trace-id:"};
  localparam logic [8*19-1:0] DEC_PREFIX   = {"x-", 8'h64, 8'h61, 8'h74, 8'h61, 8'h64,
                                              8'h6f, 8'h67, "-trace-id:"};

  typedef enum int {DIG_RANDOM, DIG_ZERO, DIG_MAX} digit_style_e;
  typedef enum int {TP_GOOD, TP_BAD_TRACE, TP_BAD_DASH, TP_BAD_SPAN} tp_fault_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } payload_item_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [2:0]   out_tuser;

  payload_item_t payload_queue[$];    // words waiting to be sent
  logic [7:0]    msg_bytes[$];        // message under construction
  thide_result_t pending_headers[$];  // decoded headers not yet seen on out_

  // decoder copy of the block state
  logic [7:0]  head_bytes[HEAD_BYTES];
  int unsigned byte_count;

  payload_item_t next_item;
  thide_result_t header_want;
  int          mismatches   = 0;
  int          headers_seen = 0;
  int          hold_mark    = 0;
  int          hold_cycles  = 0;
  int          cycle_count  = 0;
  int          tx_gap       = 0;
  int          tx_calm      = 0;
  int          rx_stall     = 0;
  int          rx_calm      = 0;

  trace_header_id_extractor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  // bytes not yet received, or past the captured head, read as zero
  function automatic logic [7:0] head_at(int unsigned i);
    if (i < HEAD_BYTES && i < WINDOW_BYTES && i < byte_count) return head_bytes[i];
    return 8'h00;
  endfunction

  function automatic bit hex_pair(int unsigned p, output logic [7:0] v);
    int h;
    int l;
    h = hex_nibble(head_at(p));
    l = hex_nibble(head_at(p + 1));
    v = 8'h00;
    if (h < 0 || l < 0) return 1'b0;
    v = {h[3:0], l[3:0]};
    return 1'b1;
  endfunction

  function automatic bit prefix_match(logic [8*19-1:0] p, int n);
    for (int i = 0; i < n; i++)
      if (head_at(i) != p[8*(n-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic thide_result_t decode_header();
    thide_result_t r;
    logic [7:0]    tr[16];
    logic [7:0]    sp[8];
    logic [7:0]    v;
    logic [63:0]   acc;
    int unsigned   pos;
    r = '0;
    acc = '0;
    foreach (tr[i]) tr[i] = 8'h00;
    foreach (sp[i]) sp[i] = 8'h00;
    if (prefix_match(TP_PREFIX, 16)) begin
      // fixed layout, any fault kills the whole header
      for (int i = 0; i < 16; i++) begin
        if (!hex_pair(16 + 2 * i, v)) return '0;
        tr[i] = v;
      end
      if (head_at(48) != CH_DASH) return '0;
      for (int i = 0; i < 8; i++) begin
        if (!hex_pair(49 + 2 * i, v)) return '0;
        sp[i] = v;
      end
      r.kind = KIND_TP;
    end else if (prefix_match(COLON_PREFIX, 14)) begin
      pos = 14;
      if (head_at(pos) == CH_SPACE) pos++;
      for (int i = 0; i < 16 && pos + 1 < WINDOW_BYTES; i++) begin
        if (head_at(pos) == CH_COLON) break;
        if (!hex_pair(pos, v)) break;
        tr[i] = v;
        pos += 2;
      end
      if (head_at(pos) == CH_COLON) begin
        pos++;
        for (int i = 0; i < 8 && pos + 1 < WINDOW_BYTES; i++) begin
          if (head_at(pos) == CH_COLON || head_at(pos) == CH_CR || head_at(pos) == CH_LF)
            break;
          if (!hex_pair(pos, v)) break;
          sp[i] = v;
          pos += 2;
        end
      end
      r.kind = KIND_UT;
    end else if (prefix_match(DEC_PREFIX, 19)) begin
      // byte 19 is skipped whatever it holds
      pos = 20;
      if (head_at(pos) == CH_SPACE) pos++;
      for (int i = 0; i < 20 && pos < WINDOW_BYTES; i++) begin
        if (head_at(pos) < 8'h30 || head_at(pos) > 8'h39) break;
        acc = acc * 64'd10 + 64'(head_at(pos) - 8'h30);
        pos++;
      end
      for (int i = 0; i < 8; i++) tr[i] = acc[8*(7-i) +: 8];
      r.kind = KIND_XD;
    end else begin
      return '0;
    end
    r.found = 1'b1;
    for (int i = 0; i < 8; i++) begin
      r.trace_high = {r.trace_high[55:0], tr[i]};
      r.trace_low  = {r.trace_low[55:0], tr[8+i]};
      r.span       = {r.span[55:0], sp[i]};
    end
    return r;
  endfunction

  function automatic void clear_head();
    foreach (head_bytes[i]) head_bytes[i] = 8'h00;
    byte_count = 0;
  endfunction

  // one taken word; the last word of a message yields one header
  function automatic void absorb_byte(logic [7:0] b, logic last);
    if (byte_count < HEAD_BYTES) head_bytes[byte_count] = b;
    if (byte_count < POS_LIMIT) byte_count++;
    if (last) begin
      pending_headers.push_back(decode_header());
      clear_head();
    end
  endfunction

  // ---------------------------------------------------------------- message builders

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_prefix(logic [8*19-1:0] p, int n, int count);
    for (int i = 0; i < count; i++) msg_bytes.push_back(p[8*(n-1-i) +: 8]);
  endtask

  task automatic add_hex(int digits, digit_style_e style);
    for (int i = 0; i < digits; i++)
      case (style)
        DIG_ZERO: msg_bytes.push_back(8'h30);
        DIG_MAX:  msg_bytes.push_back(hex_char(4'hf));
        default:  msg_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      endcase
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_traceparent(digit_style_e style, tp_fault_e fault);
    add_prefix(TP_PREFIX, 16, 16);
    add_hex(32, style);
    msg_bytes.push_back(CH_DASH);
    add_hex(16, style);
    msg_bytes.push_back(CH_DASH);
    add_hex(2, DIG_RANDOM);  // flags, never decoded
    case (fault)
      TP_BAD_TRACE: msg_bytes[16 + $urandom_range(0, 31)] = non_hex();
      TP_BAD_DASH:  msg_bytes[48] = CH_DASH ^ 8'($urandom_range(1, 255));
      TP_BAD_SPAN:  msg_bytes[49 + $urandom_range(0, 15)] = non_hex();
      default: ;
    endcase
  endtask

  task automatic add_colon_form(int trace_digits, int span_digits, bit space,
                                digit_style_e style);
    add_prefix(COLON_PREFIX, 14, 14);
    if (space) msg_bytes.push_back(CH_SPACE);
    add_hex(trace_digits, style);
    msg_bytes.push_back(CH_COLON);
    add_hex(span_digits, style);
    add_text(":0:1");
  endtask

  task automatic add_decimal_form(logic [7:0] skipped, bit space, int digits, bit nines);
    add_prefix(DEC_PREFIX, 19, 19);
    msg_bytes.push_back(skipped);
    if (space) msg_bytes.push_back(CH_SPACE);
    for (int i = 0; i < digits; i++)
      msg_bytes.push_back(nines ? 8'h39 : 8'h30 + 8'($urandom_range(0, 9)));
  endtask

  // a prefix that goes wrong part way, then noise
  task automatic add_broken_prefix();
    int         k;
    logic [7:0] good;
    case ($urandom_range(0, 2))
      0: begin
        k = $urandom_range(0, 15);
        add_prefix(TP_PREFIX, 16, k);
        good = TP_PREFIX[8*(15-k) +: 8];
      end
      1: begin
        k = $urandom_range(0, 13);
        add_prefix(COLON_PREFIX, 14, k);
        good = COLON_PREFIX[8*(13-k) +: 8];
      end
      default: begin
        k = $urandom_range(0, 18);
        add_prefix(DEC_PREFIX, 19, k);
        good = DEC_PREFIX[8*(18-k) +: 8];
      end
    endcase
    msg_bytes.push_back(good ^ 8'($urandom_range(1, 255)));
    add_noise($urandom_range(0, 60));
  endtask

  task automatic truncate(int n);
    while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
  endtask

  task automatic emit_message();
    payload_item_t item;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      item.data = msg_bytes[i];
      item.last = (i == msg_bytes.size() - 1);
      payload_queue.push_back(item);
    end
    msg_bytes.delete();
  endtask

  task automatic fill_stimulus();
    int base;
    int messages;
    // directed part: each form at its extremes and each way it can fail
    add_traceparent(DIG_ZERO, TP_GOOD);      emit_message();
    add_traceparent(DIG_MAX, TP_GOOD);       emit_message();
    add_traceparent(DIG_RANDOM, TP_GOOD);    add_noise(5); emit_message();
    add_traceparent(DIG_RANDOM, TP_BAD_TRACE); emit_message();
    add_traceparent(DIG_RANDOM, TP_BAD_DASH);  emit_message();
    add_traceparent(DIG_RANDOM, TP_BAD_SPAN);  emit_message();
    // message ends inside the trace id
    add_traceparent(DIG_RANDOM, TP_GOOD);    truncate(40); emit_message();
    add_colon_form(32, 16, 1'b0, DIG_MAX);   emit_message();
    add_colon_form(6, 2, 1'b1, DIG_RANDOM);  emit_message();
    // empty trace id, span still taken
    add_colon_form(0, 16, 1'b0, DIG_RANDOM); emit_message();
    // odd digit count leaves a lone digit, so no span
    add_colon_form(3, 4, 1'b0, DIG_RANDOM);  emit_message();
    // trace id longer than 16 bytes
    add_colon_form(34, 4, 1'b1, DIG_RANDOM); emit_message();
    // span id cut by a line break
    add_prefix(COLON_PREFIX, 14, 14);
    add_hex(8, DIG_RANDOM);
    msg_bytes.push_back(CH_COLON);
    add_hex(4, DIG_RANDOM);
    msg_bytes.push_back(CH_CR);
    msg_bytes.push_back(CH_LF);
    add_hex(6, DIG_RANDOM);
    emit_message();
    add_prefix(COLON_PREFIX, 14, 14);        emit_message();
    // twenty nines wrap past 64 bits
    add_decimal_form(8'h3a, 1'b1, 20, 1'b1); emit_message();
    add_decimal_form(8'hff, 1'b0, 25, 1'b0); emit_message();
    add_decimal_form(8'h00, 1'b1, 0, 1'b0);  add_noise(3); emit_message();
    add_decimal_form(CH_SPACE, 1'b0, 5, 1'b0); emit_message();
    add_decimal_form(8'h80, 1'b0, 0, 1'b0);
    add_text(" 18446744073709551615");
    emit_message();
    add_broken_prefix();                     emit_message();
    add_broken_prefix();                     emit_message();
    msg_bytes.push_back(8'h00);              emit_message();
    msg_bytes.push_back(8'hff);              emit_message();
    // long message runs the position count into saturation
    add_traceparent(DIG_RANDOM, TP_GOOD);    add_noise(450); emit_message();

    // random part, mostly well-formed headers with random content
    base = payload_queue.size();
    messages = 0;
    while (payload_queue.size() - base < RANDOM_BYTES || messages < RANDOM_MESSAGES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_traceparent(DIG_RANDOM, ($urandom_range(0, 4) == 0) ?
                                 tp_fault_e'($urandom_range(1, 3)) : TP_GOOD);
        3, 4, 5: add_colon_form($urandom_range(0, 34), $urandom_range(0, 18),
                                1'($urandom_range(0, 1)), DIG_RANDOM);
        6, 7:    add_decimal_form(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 22), $urandom_range(0, 5) == 0);
        8:       add_noise($urandom_range(1, 40));
        default: add_broken_prefix();
      endcase
      if ($urandom_range(0, 6) == 0) truncate($urandom_range(1, msg_bytes.size()));
      else add_noise($urandom_range(0, 6));
      emit_message();
      messages++;
    end
  endtask

  // mostly no gap, some short, a few long; now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 200);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- driver

  // in_ side: a word is taken on valid and ready, then the next one or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (payload_queue.size() != 0) begin
          next_item = payload_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.data;
          in_tlast  <= next_item.last;
          tx_gap = pick_gap(tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // out_ side: compare each taken result word with the oldest decoded header
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_headers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h", $time,
                   out_tuser, out_tdata);
          mismatches++;
        end else begin
          header_want = pending_headers.pop_front();
          check_field("header_found", 64'(header_want.found), 64'(out_tuser[0]));
          check_field("header_kind", 64'(header_want.kind), 64'(out_tuser[2:1]));
          check_field("trace_id_high", header_want.trace_high, out_tdata[63:0]);
          check_field("trace_id_low", header_want.trace_low, out_tdata[127:64]);
          check_field("span_identifier", header_want.span, out_tdata[191:128]);
        end
        headers_seen <= headers_seen + 1;
      end
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // long receiver hold-offs while the sender keeps offering words, so a
  // result sits in the output and the next last byte backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (headers_seen != hold_mark && (headers_seen == 10 || headers_seen == 25)) begin
      hold_cycles <= HOLD_LEN;
      hold_mark   <= headers_seen;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL trace_header_id_extractor");
      $finish;
    end
  end

  initial begin
    clear_head();
    fill_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // wait for every word to go in and every header to come out
    do @(negedge clk);
    while (payload_queue.size() != 0 || in_tvalid || pending_headers.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS trace_header_id_extractor");
    end else begin
      $display("FAIL trace_header_id_extractor");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/thide_pkg.sv
sv/thide_parser.sv
sv/trace_header_id_extractor.sv
test/trace_header_id_extractor_test.sv
